// ===== hdl/stereo_windowed_rms_peak_assert.svh =====
// Assertion macros for the stereo windowed RMS peak meter checker.
`ifndef STEREO_WINDOWED_RMS_PEAK_ASSERT_SVH
`define STEREO_WINDOWED_RMS_PEAK_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SWRP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SWRP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/swrp_pkg.sv =====
// Shared constants, types and helpers for the stereo windowed RMS peak meter.
package swrp_pkg;

   localparam int WIN_REG_BITS  = 13;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_WORD_LSB  = 2;

   typedef logic [WIN_REG_BITS-1:0] win_reg_type;

   localparam win_reg_type WIN_RESET = 13'd1024;

   // register index codes
   localparam logic REG_WINDOW_LENGTH = 1'b0;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;

   // per-item flags worked out by the front end
   typedef struct packed {
      logic hit;   // ring entry was written in this measurement
      logic last;  // item closes the measurement
   } item_flags_type;

   // zero acts as one, anything above the ring depth acts as the depth
   function automatic logic [31:0] effective_window(input win_reg_type wl,
                                                    input logic [31:0] wmax);
      logic [31:0] wide;
      wide = 32'(wl);
      if (wide == 32'd0) begin
         return 32'd1;
      end else if (wide > wmax) begin
         return wmax;
      end else begin
         return wide;
      end
   endfunction

endpackage

// ===== hdl/swrp_front.sv =====
// Front end: accepts sample items, tracks ring position and fill, tags each item.
module swrp_front #(
   parameter int SAMPLE_BITS = 24,
   parameter int IDX_BITS    = 12,
   parameter int LEN_BITS    = 13
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  logic signed [SAMPLE_BITS-1:0]     req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0]     req_right_sample,
   input  logic                              req_is_last,
   input  logic [LEN_BITS-1:0]               len,
   input  logic                              q_full,
   output logic                              q_push,
   output logic [2*SAMPLE_BITS+IDX_BITS+1:0] q_data
);
   import swrp_pkg::*;

   logic [IDX_BITS-1:0] pos_ff, pos_in;
   logic [LEN_BITS-1:0] fill_ff, fill_in;
   logic [LEN_BITS-1:0] pos_next;
   logic                accept;
   item_flags_type      flags;

   assign accept   = push && !q_full;
   assign pos_next = LEN_BITS'(pos_ff) + LEN_BITS'(1);

   // written entries always form a prefix of the ring, so a fill mark
   // stands in for clearing it
   always_comb begin
      pos_in     = pos_ff;
      fill_in    = fill_ff;
      flags.hit  = LEN_BITS'(pos_ff) < fill_ff;
      flags.last = req_is_last;
      if (accept) begin
         if (req_is_last) begin
            pos_in  = '0;
            fill_in = '0;
         end else begin
            pos_in  = (pos_next >= len) ? '0 : pos_next[IDX_BITS-1:0];
            fill_in = (pos_next > fill_ff) ? pos_next : fill_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         fill_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         fill_ff <= fill_in;
      end
   end

   assign q_push = accept;
   assign q_data = {req_left_sample, req_right_sample, flags, pos_ff};

endmodule

// ===== hdl/swrp_queue.sv =====
// Short item queue between front end and window engine.
module swrp_queue #(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   import swrp_pkg::*;

   logic [WIDTH-1:0]          slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;

   assign full    = count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== hdl/swrp_engine.sv =====
// Window engine: squares, ring read-modify-write, running sums and peaks.
module swrp_engine #(
   parameter int SAMPLE_BITS = 24,
   parameter int WINDOW_MAX  = 4096,
   parameter int IDX_BITS    = 12,
   parameter int SQ_BITS     = 47,
   parameter int SUM_BITS    = 59
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   input  logic [2*SAMPLE_BITS+IDX_BITS+1:0] q_data,
   output logic                              q_pop,
   input  logic                              root_idle,
   output logic                              peak_start,
   output logic [SUM_BITS-1:0]               peak_left,
   output logic [SUM_BITS-1:0]               peak_right
);
   import swrp_pkg::*;

   // queue head
   logic [SAMPLE_BITS-1:0]   head_left, head_right;
   logic [SAMPLE_BITS-1:0]   mag_left, mag_right;
   logic [2*SAMPLE_BITS-1:0] prod_left, prod_right;
   item_flags_type           head_flags;
   logic [IDX_BITS-1:0]      head_pos;

   // ring memories
   logic [SQ_BITS-1:0] ring_left  [WINDOW_MAX];
   logic [SQ_BITS-1:0] ring_right [WINDOW_MAX];
   logic [SQ_BITS-1:0] ring_rd_left_ff, ring_rd_right_ff;

   // stage 1: square ready, ring data ready
   logic                s1_valid_ff, s1_last_ff, s1_hit_ff, s1_fwd_ff;
   logic [IDX_BITS-1:0] s1_pos_ff;
   logic [SQ_BITS-1:0]  s1_sq_left_ff, s1_sq_right_ff;
   logic [SQ_BITS-1:0]  s1_fwd_left_ff, s1_fwd_right_ff;
   logic [SQ_BITS-1:0]  old_left, old_right;
   logic [SUM_BITS-1:0] new_sum_left, new_sum_right;
   logic [SUM_BITS-1:0] sum_left_ff, sum_left_in, sum_right_ff, sum_right_in;

   // stage 2: peak update
   logic                s2_valid_ff, s2_last_ff;
   logic [SUM_BITS-1:0] s2_sum_left_ff, s2_sum_right_ff;
   logic [SUM_BITS-1:0] peak_left_ff, peak_left_in, peak_right_ff, peak_right_in;

   assign {head_left, head_right, head_flags, head_pos} = q_data;

   // a closing item enters only when the root unit will be free for it
   assign q_pop = !q_empty &&
                  (!head_flags.last ||
                   (root_idle && !(s1_valid_ff && s1_last_ff) &&
                    !(s2_valid_ff && s2_last_ff)));

   assign mag_left   = head_left[SAMPLE_BITS-1] ? (~head_left + SAMPLE_BITS'(1)) : head_left;
   assign mag_right  = head_right[SAMPLE_BITS-1] ? (~head_right + SAMPLE_BITS'(1)) : head_right;
   assign prod_left  = {{SAMPLE_BITS{1'b0}}, mag_left} * {{SAMPLE_BITS{1'b0}}, mag_left};
   assign prod_right = {{SAMPLE_BITS{1'b0}}, mag_right} * {{SAMPLE_BITS{1'b0}}, mag_right};

   // read-first ring; stage 1 writes back the new square
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         ring_left[s1_pos_ff]  <= s1_sq_left_ff;
         ring_right[s1_pos_ff] <= s1_sq_right_ff;
      end
      ring_rd_left_ff  <= ring_left[head_pos];
      ring_rd_right_ff <= ring_right[head_pos];
   end

   // stage 1: old entry (forwarded when the previous item wrote the same slot)
   always_comb begin
      old_left  = '0;
      old_right = '0;
      if (s1_hit_ff) begin
         old_left  = s1_fwd_ff ? s1_fwd_left_ff  : ring_rd_left_ff;
         old_right = s1_fwd_ff ? s1_fwd_right_ff : ring_rd_right_ff;
      end
      new_sum_left  = sum_left_ff  - SUM_BITS'(old_left)  + SUM_BITS'(s1_sq_left_ff);
      new_sum_right = sum_right_ff - SUM_BITS'(old_right) + SUM_BITS'(s1_sq_right_ff);
      sum_left_in   = sum_left_ff;
      sum_right_in  = sum_right_ff;
      if (s1_valid_ff) begin
         sum_left_in  = s1_last_ff ? '0 : new_sum_left;
         sum_right_in = s1_last_ff ? '0 : new_sum_right;
      end
   end

   // stage 2: peak tracking, hand-off on a closing item
   always_comb begin
      peak_left  = (s2_sum_left_ff  > peak_left_ff)  ? s2_sum_left_ff  : peak_left_ff;
      peak_right = (s2_sum_right_ff > peak_right_ff) ? s2_sum_right_ff : peak_right_ff;
      peak_start = s2_valid_ff && s2_last_ff;
      peak_left_in  = peak_left_ff;
      peak_right_in = peak_right_ff;
      if (s2_valid_ff) begin
         peak_left_in  = s2_last_ff ? '0 : peak_left;
         peak_right_in = s2_last_ff ? '0 : peak_right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         sum_left_ff   <= '0;
         sum_right_ff  <= '0;
         peak_left_ff  <= '0;
         peak_right_ff <= '0;
      end else begin
         s1_valid_ff   <= q_pop;
         s2_valid_ff   <= s1_valid_ff;
         sum_left_ff   <= sum_left_in;
         sum_right_ff  <= sum_right_in;
         peak_left_ff  <= peak_left_in;
         peak_right_ff <= peak_right_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff       <= head_flags.last;
      s1_hit_ff        <= head_flags.hit;
      s1_pos_ff        <= head_pos;
      s1_sq_left_ff    <= prod_left[SQ_BITS-1:0];
      s1_sq_right_ff   <= prod_right[SQ_BITS-1:0];
      s1_fwd_ff        <= s1_valid_ff && (s1_pos_ff == head_pos);
      s1_fwd_left_ff   <= s1_sq_left_ff;
      s1_fwd_right_ff  <= s1_sq_right_ff;
      s2_last_ff       <= s1_last_ff;
      s2_sum_left_ff   <= new_sum_left;
      s2_sum_right_ff  <= new_sum_right;
   end

endmodule

// ===== hdl/swrp_root.sv =====
// Root unit: serial divide by window length, serial square root, result register.
module swrp_root #(
   parameter int SAMPLE_BITS = 24,
   parameter int SUM_BITS    = 59,
   parameter int LEN_BITS    = 13,
   parameter int RT_BITS     = 30
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SUM_BITS-1:0]    peak_left,
   input  logic [SUM_BITS-1:0]    peak_right,
   input  logic [LEN_BITS-1:0]    len,
   output logic                   idle,
   output logic                   empty,
   input  logic                   pop,
   output logic [SAMPLE_BITS-1:0] rsp_rms_left,
   output logic [SAMPLE_BITS-1:0] rsp_rms_right
);

   localparam int CNT_BITS = $clog2(SUM_BITS + 1);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_SQRT = 2'd2;
   localparam logic [1:0] ST_HOLD = 2'd3;
   localparam logic [RT_BITS-1:0] FULL_SCALE = RT_BITS'(1) << (SAMPLE_BITS - 1);

   logic [1:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [LEN_BITS-1:0] len_ff, len_in;

   logic [1:0][SUM_BITS-1:0]  dvd_ff, dvd_in, dvd_step;
   logic [1:0][LEN_BITS-1:0]  rem_ff, rem_in, rem_step;
   logic [1:0][LEN_BITS:0]    rem_sh;
   logic [1:0]                qbit;

   logic [1:0][2*RT_BITS-1:0] x_ff, x_in;
   logic [1:0][RT_BITS+1:0]   srem_ff, srem_in;
   logic [1:0][RT_BITS+3:0]   srem_sh, trial;
   logic [1:0][RT_BITS-1:0]   root_ff, root_in, root_step, sat;
   logic [1:0]                sbit;

   logic                         out_valid_ff, out_valid_in, load_out;
   logic [1:0][SAMPLE_BITS-1:0]  out_ff, out_in;

   // one quotient bit and one root bit per cycle, both channels side by side
   always_comb begin
      for (int ch = 0; ch < 2; ch++) begin
         rem_sh[ch]    = {rem_ff[ch], dvd_ff[ch][SUM_BITS-1]};
         qbit[ch]      = rem_sh[ch] >= {1'b0, len_ff};
         rem_step[ch]  = qbit[ch] ? LEN_BITS'(rem_sh[ch] - {1'b0, len_ff})
                                  : rem_sh[ch][LEN_BITS-1:0];
         dvd_step[ch]  = {dvd_ff[ch][SUM_BITS-2:0], qbit[ch]};
         srem_sh[ch]   = {srem_ff[ch], x_ff[ch][2*RT_BITS-1 -: 2]};
         trial[ch]     = {2'b00, root_ff[ch], 2'b01};
         sbit[ch]      = srem_sh[ch] >= trial[ch];
         root_step[ch] = {root_ff[ch][RT_BITS-2:0], sbit[ch]};
         sat[ch]       = (root_ff[ch] > FULL_SCALE) ? FULL_SCALE : root_ff[ch];
      end
   end

   assign load_out = (state_ff == ST_HOLD) && (!out_valid_ff || pop);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      len_in       = len_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      x_in         = x_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               dvd_in[0] = peak_left;
               dvd_in[1] = peak_right;
               rem_in    = '0;
               len_in    = len;
               cnt_in    = '0;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            dvd_in = dvd_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(SUM_BITS - 1)) begin
               for (int ch = 0; ch < 2; ch++) begin
                  x_in[ch] = (2*RT_BITS)'(dvd_step[ch]);
               end
               srem_in  = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            for (int ch = 0; ch < 2; ch++) begin
               srem_in[ch] = sbit[ch] ? (RT_BITS+2)'(srem_sh[ch] - trial[ch])
                                      : srem_sh[ch][RT_BITS+1:0];
               x_in[ch]    = {x_ff[ch][2*RT_BITS-3:0], 2'b00};
            end
            root_in = root_step;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(RT_BITS - 1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (load_out) begin
               for (int ch = 0; ch < 2; ch++) begin
                  out_in[ch] = sat[ch][SAMPLE_BITS-1:0];
               end
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      x_ff    <= x_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      out_ff  <= out_in;
   end

   assign idle          = state_ff == ST_IDLE;
   assign empty         = !out_valid_ff;
   assign rsp_rms_left  = out_ff[0];
   assign rsp_rms_right = out_ff[1];

endmodule

// ===== hdl/stereo_windowed_rms_peak.sv =====
// Top level of the stereo sliding-window RMS peak meter.
//
//   port group  direction  handshake            carries
//   req_*       in         push / full          left, right sample pair, is_last
//   rsp_*       out        empty / pop          peak windowed RMS, left and right
//   p*          in/out     psel, penable, ...   window_length at byte address 0
//
// Items move through at one per cycle while no last item waits: the ring
// read-modify-write is pipelined (read, sum update and write-back, peak compare).
// An item marked last hands its peaks to the root unit, which runs a restoring
// division, then a square root, then loads the result register when it frees.
// Items keep flowing meanwhile; only a second last item waits for the root unit,
// and the items queued behind it wait with it.
// Synchronous active-high reset; the rings need no clearing pass, a fill mark
// in the front end masks entries not yet written in the current measurement.
module stereo_windowed_rms_peak #(
   parameter int WINDOW_MAX  = 4096,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   // sample items
   input  logic                                push,
   output logic                                full,
   input  logic signed [SAMPLE_BITS-1:0]       req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0]       req_right_sample,
   input  logic                                req_is_last,
   // result items
   output logic                                empty,
   input  logic                                pop,
   output logic [SAMPLE_BITS-1:0]              rsp_rms_left,
   output logic [SAMPLE_BITS-1:0]              rsp_rms_right,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [swrp_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [swrp_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [swrp_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready
);
   import swrp_pkg::*;

   localparam int IDX_BITS  = $clog2(WINDOW_MAX);
   localparam int LEN_BITS  = $clog2(WINDOW_MAX + 1);
   localparam int SQ_BITS   = 2 * SAMPLE_BITS - 1;
   // sums are exact up to 64 bits, wrap beyond
   localparam int SUM_WIDE  = SQ_BITS + IDX_BITS;
   localparam int SUM_BITS  = (SUM_WIDE > 64) ? 64 : SUM_WIDE;
   localparam int RT_BITS   = (SUM_BITS + 1) / 2;
   localparam int ITEM_BITS = 2 * SAMPLE_BITS + IDX_BITS + 2;

   // register file
   win_reg_type         window_ff;
   logic                reg_sel;
   logic                reg_write;
   logic [LEN_BITS-1:0] len;

   // front to queue
   logic                 q_push, q_full;
   logic [ITEM_BITS-1:0] q_wr_data;
   // queue to engine
   logic                 q_pop, q_empty;
   logic [ITEM_BITS-1:0] q_rd_data;
   // engine to root unit
   logic                 root_idle, peak_start;
   logic [SUM_BITS-1:0]  peak_left, peak_right;

   // register index is the word address; low byte bits are ignored
   assign reg_sel   = paddr[CSR_ADDR_BITS-1:CSR_WORD_LSB] == REG_WINDOW_LENGTH;
   assign reg_write = psel && penable && pwrite && reg_sel;
   assign pready    = 1'b1;
   assign prdata    = reg_sel ? CSR_DATA_BITS'(window_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WIN_RESET;
      end else if (reg_write) begin
         window_ff <= pwdata[WIN_REG_BITS-1:0];
      end
   end

   // clamped window; keeping it stable whenever items are in flight is up to the user, not enforced here
   assign len = LEN_BITS'(effective_window(window_ff, 32'(WINDOW_MAX)));

   swrp_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .IDX_BITS    (IDX_BITS),
      .LEN_BITS    (LEN_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .req_is_last      (req_is_last),
      .len              (len),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_wr_data)
   );

   swrp_queue #(
      .WIDTH (ITEM_BITS)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   assign full = q_full;

   swrp_engine #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .WINDOW_MAX  (WINDOW_MAX),
      .IDX_BITS    (IDX_BITS),
      .SQ_BITS     (SQ_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (q_rd_data),
      .q_pop      (q_pop),
      .root_idle  (root_idle),
      .peak_start (peak_start),
      .peak_left  (peak_left),
      .peak_right (peak_right)
   );

   swrp_root #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_BITS    (SUM_BITS),
      .LEN_BITS    (LEN_BITS),
      .RT_BITS     (RT_BITS)
   ) u_root (
      .clock         (clock),
      .reset         (reset),
      .start         (peak_start),
      .peak_left     (peak_left),
      .peak_right    (peak_right),
      .len           (len),
      .idle          (root_idle),
      .empty         (empty),
      .pop           (pop),
      .rsp_rms_left  (rsp_rms_left),
      .rsp_rms_right (rsp_rms_right)
   );

endmodule

// ===== hdl/swrp_checker.sv =====
// Port-level checker for the stereo windowed RMS peak meter, with its bind.
`include "stereo_windowed_rms_peak_assert.svh"

module swrp_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                push,
   input logic                                full,
   input logic                                req_is_last,
   input logic                                empty,
   input logic                                pop,
   input logic [SAMPLE_BITS-1:0]              rsp_rms_left,
   input logic [SAMPLE_BITS-1:0]              rsp_rms_right,
   input logic                                psel,
   input logic                                penable,
   input logic                                pwrite,
   input logic [swrp_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input logic [swrp_pkg::CSR_DATA_BITS-1:0]  pwdata,
   input logic [swrp_pkg::CSR_DATA_BITS-1:0]  prdata
);
   import swrp_pkg::*;

   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

   // closing items pushed whose result has not been taken yet
   logic [3:0] pend_ff;
   logic       last_in, result_out;

   assign last_in    = push && !full && req_is_last;
   assign result_out = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else if (last_in && !result_out) begin
         pend_ff <= pend_ff + 1'b1;
      end else if (result_out && !last_in) begin
         pend_ff <= pend_ff - 1'b1;
      end
   end

   `SWRP_ASSERT_NOW(a_result_has_last, clock, reset, !empty, pend_ff != 4'd0, "result with no closing item pending")

   `SWRP_ASSERT_NOW(a_rms_in_range, clock, reset, !empty, (rsp_rms_left <= FULL_SCALE) && (rsp_rms_right <= FULL_SCALE), "RMS above full scale")

   `SWRP_ASSERT_NEXT(a_result_holds, clock, reset, !empty && !pop, !empty && $stable(rsp_rms_left) && $stable(rsp_rms_right), "waiting result changed")

   `SWRP_ASSERT_NEXT(a_window_readback, clock, reset, psel && penable && pwrite && (paddr[CSR_ADDR_BITS-1:CSR_WORD_LSB] == REG_WINDOW_LENGTH), (paddr[CSR_ADDR_BITS-1:CSR_WORD_LSB] != REG_WINDOW_LENGTH) || (prdata[WIN_REG_BITS-1:0] == $past(pwdata[WIN_REG_BITS-1:0])), "window length readback mismatch")

endmodule

bind stereo_windowed_rms_peak swrp_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
   .clock         (clock),
   .reset         (reset),
   .push          (push),
   .full          (full),
   .req_is_last   (req_is_last),
   .empty         (empty),
   .pop           (pop),
   .rsp_rms_left  (rsp_rms_left),
   .rsp_rms_right (rsp_rms_right),
   .psel          (psel),
   .penable       (penable),
   .pwrite        (pwrite),
   .paddr         (paddr),
   .pwdata        (pwdata),
   .prdata        (prdata)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for the stereo sliding-window RMS peak meter.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import swrp_pkg::*;

   localparam int RING_DEPTH    = 4096;
   localparam int SAMPLE_W      = 24;
   localparam int RANDOM_ITEMS  = 560;
   localparam int SETTLE_CYCLES = 160;     // longer than one root unit run
   localparam int HOLD_CYCLES   = 1500;    // long receiver stall, backs results up into the item queue
   localparam int CYCLE_LIMIT   = 400000;

   localparam logic signed [SAMPLE_W-1:0] FULL_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] FULL_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic [63:0] FULL_SCALE = 64'd1 << (SAMPLE_W-1);
   localparam logic [CSR_ADDR_BITS-1:0] WINDOW_ADDR =
      CSR_ADDR_BITS'(REG_WINDOW_LENGTH) << CSR_WORD_LSB;

   typedef struct packed {
      logic [SAMPLE_W-1:0] rms_left;
      logic [SAMPLE_W-1:0] rms_right;
   } meter_reading_t;

   // receiver behavior, chosen per phase
   typedef enum {POP_ALWAYS, POP_RANDOM, POP_STALLED} pop_mode_t;

   logic                                clock;
   logic                                reset;
   logic                                push;
   logic                                full;
   logic signed [SAMPLE_W-1:0]          req_left_sample;
   logic signed [SAMPLE_W-1:0]          req_right_sample;
   logic                                req_is_last;
   logic                                empty;
   logic                                pop;
   logic [SAMPLE_W-1:0]                 rsp_rms_left;
   logic [SAMPLE_W-1:0]                 rsp_rms_right;
   logic                                psel;
   logic                                penable;
   logic                                pwrite;
   logic [CSR_ADDR_BITS-1:0]            paddr;
   logic [CSR_DATA_BITS-1:0]            pwdata;
   logic [CSR_DATA_BITS-1:0]            prdata;
   logic                                pready;

   stereo_windowed_rms_peak #(
      .WINDOW_MAX  (RING_DEPTH),
      .SAMPLE_BITS (SAMPLE_W)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .req_is_last      (req_is_last),
      .empty            (empty),
      .pop              (pop),
      .rsp_rms_left     (rsp_rms_left),
      .rsp_rms_right    (rsp_rms_right),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // ---------------------------------------------------------------------
   // Meter state mirror: power rings, running window energy, peak energy.
   // ---------------------------------------------------------------------
   logic [2*SAMPLE_W-2:0] left_power_ring  [RING_DEPTH];
   logic [2*SAMPLE_W-2:0] right_power_ring [RING_DEPTH];
   int unsigned           write_slot;
   logic [63:0]           left_energy, right_energy;
   logic [63:0]           left_energy_peak, right_energy_peak;
   win_reg_type           window_setting;

   meter_reading_t        expected_readings[$];
   meter_reading_t        reading_due;
   int                    error_count  = 0;
   int                    items_sent   = 0;
   int                    cycle_count  = 0;

   // sender burst control
   bit                    gaps_enabled = 1'b1;
   int                    burst_left   = 0;

   // long receiver hold requested by a test, counted out by the receiver
   int                    hold_serial  = 0;

   function automatic void clear_meter();
      for (int i = 0; i < RING_DEPTH; i++) begin
         left_power_ring[i]  = '0;
         right_power_ring[i] = '0;
      end
      write_slot        = 0;
      left_energy       = '0;
      right_energy      = '0;
      left_energy_peak  = '0;
      right_energy_peak = '0;
   endfunction

   // zero means one sample, anything past the ring depth means the full ring
   function automatic int unsigned active_span();
      if (window_setting == '0) begin
         return 1;
      end else if (int'(window_setting) > RING_DEPTH) begin
         return RING_DEPTH;
      end
      return int'(window_setting);
   endfunction

   function automatic logic [2*SAMPLE_W-2:0] sample_power(
      input logic signed [SAMPLE_W-1:0] s);
      logic [SAMPLE_W-1:0] mag;
      logic [2*SAMPLE_W-1:0] prod;
      mag  = s[SAMPLE_W-1] ? (~s + 1'b1) : s;   // most negative maps to 2^23
      prod = mag * mag;
      return prod[2*SAMPLE_W-2:0];
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] value);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= value) begin
            root = trial;
         end
      end
      return root;
   endfunction

   function automatic logic [SAMPLE_W-1:0] peak_rms(input logic [63:0] energy,
                                                    input int unsigned span);
      logic [63:0] root;
      root = int_sqrt(energy / 64'(span));
      if (root > FULL_SCALE) begin
         root = FULL_SCALE;                        // only after a window shrink
      end
      return root[SAMPLE_W-1:0];
   endfunction

   // One accepted item: replace the oldest ring power, update energy and peak,
   // and on the closing item produce the reading and start a new measurement.
   function automatic void advance_meter(input logic signed [SAMPLE_W-1:0] left_s,
                                         input logic signed [SAMPLE_W-1:0] right_s,
                                         input logic last_flag,
                                         output logic produced,
                                         output meter_reading_t reading);
      int unsigned span;
      logic [2*SAMPLE_W-2:0] left_pow;
      logic [2*SAMPLE_W-2:0] right_pow;
      span      = active_span();
      left_pow  = sample_power(left_s);
      right_pow = sample_power(right_s);
      left_energy  = left_energy  - left_power_ring[write_slot]  + left_pow;
      right_energy = right_energy - right_power_ring[write_slot] + right_pow;
      left_power_ring[write_slot]  = left_pow;
      right_power_ring[write_slot] = right_pow;
      if (left_energy > left_energy_peak) begin
         left_energy_peak = left_energy;
      end
      if (right_energy > right_energy_peak) begin
         right_energy_peak = right_energy;
      end
      // slots past a shrunk window stay in the energy until overwritten
      write_slot = (write_slot + 1 >= span) ? 0 : write_slot + 1;
      produced = last_flag;
      reading  = '0;
      if (last_flag) begin
         reading.rms_left  = peak_rms(left_energy_peak, span);
         reading.rms_right = peak_rms(right_energy_peak, span);
         clear_meter();
      end
   endfunction

   // ---------------------------------------------------------------------
   // Clock, cycle limit
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout, %0d readings still outstanding", $time,
               expected_readings.size());
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver: phases of free popping, random stalls and full stalls, plus
   // a long hold whenever a test asks for one.
   // ---------------------------------------------------------------------
   initial begin
      int        holds_seen;
      int        phase_left;
      pop_mode_t phase_mode;
      pop        = 1'b0;
      holds_seen = 0;
      phase_left = 0;
      phase_mode = POP_ALWAYS;
      forever begin
         @(negedge clock);
         if (hold_serial != holds_seen) begin
            holds_seen = hold_serial;
            pop = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (phase_left == 0) begin
            case ($urandom_range(0, 3))
               0, 1:    phase_mode = POP_ALWAYS;
               2:       phase_mode = POP_RANDOM;
               default: phase_mode = POP_STALLED;
            endcase
            phase_left = (phase_mode == POP_STALLED) ? $urandom_range(1, 30)
                                                     : $urandom_range(8, 64);
         end
         phase_left--;
         case (phase_mode)
            POP_ALWAYS:  pop = 1'b1;
            POP_RANDOM:  pop = 1'($urandom_range(0, 1));
            default:     pop = 1'b0;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: every popped reading against the oldest expectation.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (expected_readings.size() == 0) begin
            $display("%0t: unexpected reading, expected none, got left %0d right %0d",
                     $time, rsp_rms_left, rsp_rms_right);
            error_count++;
         end else begin
            reading_due = expected_readings.pop_front();
            if (rsp_rms_left !== reading_due.rms_left) begin
               $display("%0t: rms_left mismatch, expected %0d, got %0d",
                        $time, reading_due.rms_left, rsp_rms_left);
               error_count++;
            end
            if (rsp_rms_right !== reading_due.rms_right) begin
               $display("%0t: rms_right mismatch, expected %0d, got %0d",
                        $time, reading_due.rms_right, rsp_rms_right);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driver tasks. All of them start and end at a falling edge.
   // ---------------------------------------------------------------------
   task automatic send_sample_pair(input logic signed [SAMPLE_W-1:0] left_s,
                                   input logic signed [SAMPLE_W-1:0] right_s,
                                   input logic last_flag);
      int             gap;
      logic           produced;
      meter_reading_t reading;
      if (gaps_enabled && burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         repeat (gap) @(negedge clock);
         // mostly short bursts, now and then a long unbroken run
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 16);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      req_left_sample  = left_s;
      req_right_sample = right_s;
      req_is_last      = last_flag;
      push             = 1'b1;
      do @(posedge clock); while (full);
      advance_meter(left_s, right_s, last_flag, produced, reading);
      if (produced) begin
         expected_readings.push_back(reading);
      end
      items_sent++;
      @(negedge clock);
      push = 1'b0;
   endtask

   task automatic drain_readings();
      while (expected_readings.size() != 0) @(negedge clock);
   endtask

   // items without a reading may still be in the pipe after the last reading
   task automatic settle_meter();
      drain_readings();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic read_window_reg(input win_reg_type want);
      logic [CSR_DATA_BITS-1:0] got;
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = WINDOW_ADDR;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      if (got !== CSR_DATA_BITS'(want)) begin
         $display("%0t: window_length readback mismatch, expected %0d, got %0d",
                  $time, want, got);
         error_count++;
      end
   endtask

   // upper data bits carry noise; only the register width is kept
   task automatic set_window(input win_reg_type value);
      logic [CSR_DATA_BITS-1:0] word;
      settle_meter();
      word = CSR_DATA_BITS'($urandom);
      word[WIN_REG_BITS-1:0] = value;
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = WINDOW_ADDR;
      pwdata  = word;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      window_setting = value;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      read_window_reg(value);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return FULL_NEG;
         1:       return FULL_POS;
         2:       return SAMPLE_W'($urandom_range(0, 511) - 256);   // near silence
         3:       return $signed(SAMPLE_W'($urandom)) >>> $urandom_range(1, 20);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic win_reg_type random_window();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return win_reg_type'(1);
         2:       return win_reg_type'(2);
         3:       return win_reg_type'(RING_DEPTH);
         4:       return win_reg_type'($urandom_range(RING_DEPTH + 1, 8191));
         5:       return WIN_RESET;
         6, 7, 8, 9, 10, 11, 12, 13:
                  return win_reg_type'($urandom_range(1, 16));
         default: return win_reg_type'($urandom_range(17, 200));
      endcase
   endfunction

   function automatic int random_run_length();
      int unsigned span;
      span = active_span();
      if (span <= 16) begin
         return $urandom_range(1, 2 * span + 2);
      end else if ($urandom_range(0, 19) == 0) begin
         return $urandom_range(1, (span > 200) ? 200 : 2 * span);  // rare long run
      end
      return $urandom_range(1, 32);
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_reset_window_value();
      read_window_reg(WIN_RESET);
   endtask

   // full-scale and near-zero samples, both signs, at reset and tiny windows
   task automatic test_sample_extremes();
      send_sample_pair(FULL_NEG, FULL_POS, 1'b1);        // reset window length
      set_window(win_reg_type'(4));
      send_sample_pair(FULL_NEG, FULL_POS, 1'b0);
      send_sample_pair('0, '0, 1'b0);
      send_sample_pair(FULL_POS, FULL_NEG, 1'b0);
      send_sample_pair(-1, 1, 1'b0);
      send_sample_pair(1, -1, 1'b1);
      send_sample_pair('0, '0, 1'b1);                    // silent measurement
   endtask

   // zero acts as one, oversize values clamp to the ring depth
   task automatic test_window_limits();
      set_window('0);
      send_sample_pair(FULL_NEG, FULL_POS, 1'b1);        // exactly full scale
      set_window(win_reg_type'(8191));
      send_sample_pair(FULL_POS, 1, 1'b0);
      send_sample_pair(FULL_NEG, -1, 1'b1);
      set_window(win_reg_type'(RING_DEPTH));
      send_sample_pair(FULL_NEG, FULL_NEG, 1'b1);
      set_window(win_reg_type'(1));
      send_sample_pair(3, -5, 1'b0);
      send_sample_pair(FULL_POS, '0, 1'b0);
      send_sample_pair(-7, FULL_NEG, 1'b1);
   endtask

   // window length rewritten while a measurement is open
   task automatic test_window_change_midway();
      // shrink to one after two full-scale powers: reading saturates
      set_window(win_reg_type'(2));
      send_sample_pair(FULL_NEG, FULL_POS, 1'b0);
      send_sample_pair(FULL_NEG, FULL_POS, 1'b0);
      set_window(win_reg_type'(1));
      send_sample_pair('0, '0, 1'b1);
      // grow: new slots join the window
      set_window(win_reg_type'(3));
      repeat (4) send_sample_pair(random_sample(), random_sample(), 1'b0);
      set_window(win_reg_type'(6));
      send_sample_pair(random_sample(), random_sample(), 1'b0);
      send_sample_pair(random_sample(), random_sample(), 1'b1);
      // shrink with the write slot past the new length
      set_window(win_reg_type'(8));
      repeat (6) send_sample_pair(random_sample(), random_sample(), 1'b0);
      set_window(win_reg_type'(2));
      send_sample_pair(random_sample(), random_sample(), 1'b0);
      send_sample_pair(random_sample(), random_sample(), 1'b1);
   endtask

   task automatic test_random_measurements();
      int target;
      int run_len;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         set_window(random_window());
         repeat ($urandom_range(1, 4)) begin
            run_len = random_run_length();
            for (int i = 0; i < run_len; i++) begin
               send_sample_pair(random_sample(), random_sample(), i == run_len - 1);
            end
            if ($urandom_range(0, 7) == 0) begin
               drain_readings();                     // sender waits out the results
            end
         end
         // sometimes leave the measurement open across the next window change
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 12)) begin
               send_sample_pair(random_sample(), random_sample(), 1'b0);
            end
         end
      end
   endtask

   // receiver holds off while the sender keeps offering closing items
   task automatic test_output_backpressure();
      set_window(win_reg_type'($urandom_range(1, 8)));
      gaps_enabled = 1'b0;
      hold_serial++;
      for (int i = 0; i < 24; i++) begin
         send_sample_pair(random_sample(), random_sample(), i[0]);
      end
      gaps_enabled = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      push             = 1'b0;
      req_left_sample  = '0;
      req_right_sample = '0;
      req_is_last      = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      clear_meter();
      window_setting   = WIN_RESET;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      test_reset_window_value();
      test_sample_extremes();
      test_window_limits();
      test_window_change_midway();
      test_output_backpressure();
      test_random_measurements();

      // nothing left outstanding, then watch for stray readings
      settle_meter();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/swrp_pkg.sv
hdl/swrp_front.sv
hdl/swrp_queue.sv
hdl/swrp_engine.sv
hdl/swrp_root.sv
hdl/stereo_windowed_rms_peak.sv
hdl/swrp_checker.sv
verif/testbench.sv
